### sv/sspf_pkg.sv
// shared types and constants for the sysex serial patch filter
package sspf_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t SYX_START = 8'hF0;
    localparam byte_t SYX_END   = 8'hF7;
    localparam logic [6:0] LOW7 = 7'h7F;

    // frame position of the first serial field byte
    localparam int FIELD_FIRST = 7;
    // first frame position that counts toward the checksum
    localparam int SUM_FIRST = 5;

    localparam int NUM_SERIAL_REGS = 5;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_SERIAL_0 = 3'd0,
        REG_SERIAL_1 = 3'd1,
        REG_SERIAL_2 = 3'd2,
        REG_SERIAL_3 = 3'd3,
        REG_SERIAL_4 = 3'd4
    } reg_idx_t;

    typedef logic [NUM_SERIAL_REGS-1:0][7:0] serial_cfg_t;

    // flags that travel with one result group
    typedef struct packed {
        logic last;
        logic abort;
    } grp_ctrl_t;

endpackage

### sv/sspf_regs.sv
// apb register file holding the substituted serial number bytes
module sspf_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sspf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sspf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sspf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sspf_pkg::serial_cfg_t          serial_cfg
);
    import sspf_pkg::*;

    serial_cfg_t serial_reg;
    serial_cfg_t serial_next;
    logic [2:0]  reg_idx;
    logic        wr_en;
    byte_t       rd_byte;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        serial_next = serial_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SERIAL_0: serial_next[0] = pwdata[7:0];
                REG_SERIAL_1: serial_next[1] = pwdata[7:0];
                REG_SERIAL_2: serial_next[2] = pwdata[7:0];
                REG_SERIAL_3: serial_next[3] = pwdata[7:0];
                REG_SERIAL_4: serial_next[4] = pwdata[7:0];
                default:      serial_next = serial_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SERIAL_0: rd_byte = serial_reg[0];
            REG_SERIAL_1: rd_byte = serial_reg[1];
            REG_SERIAL_2: rd_byte = serial_reg[2];
            REG_SERIAL_3: rd_byte = serial_reg[3];
            REG_SERIAL_4: rd_byte = serial_reg[4];
            default:      rd_byte = '0;
        endcase
    end

    assign prdata     = {{(CFG_DATA_W-8){1'b0}}, rd_byte};
    assign serial_cfg = serial_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg <= '0;
        end
        else
        begin
            serial_reg <= serial_next;
        end
    end

endmodule

### sv/sspf_core.sv
// frame tracking, serial substitution and checksum; builds one result group per word
module sspf_core #(
    parameter int SERIAL_LENGTH = 5,
    parameter int MAX_RESULTS   = 5,
    parameter int CNT_W         = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [7:0]                          data_byte,
    input  logic                                chunk_end,
    input  sspf_pkg::serial_cfg_t               serial_cfg,
    output logic [CNT_W-1:0]                    grp_cnt,
    output logic [MAX_RESULTS-1:0][7:0]         grp_bytes,
    output sspf_pkg::grp_ctrl_t                 grp_ctrl
);
    import sspf_pkg::*;

    localparam int FIELD_LAST = FIELD_FIRST + SERIAL_LENGTH - 1;
    localparam int POS_SAT    = FIELD_LAST + 2;
    localparam int POS_W      = $clog2(POS_SAT + 1);
    localparam int HOLD_W     = (SERIAL_LENGTH > 1) ? $clog2(SERIAL_LENGTH) : 1;

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    byte_t            pend_byte_reg, pend_byte_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [6:0]       sum_reg, sum_next;
    logic             subst_reg, subst_next;

    byte_t              hold_reg [SERIAL_LENGTH];
    logic               hold_wr;
    logic [POS_W-1:0]   field_off;
    byte_t              cfg_ext [SERIAL_LENGTH];
    logic               field_zero;

    // serial bytes past the fifth register read as zero
    for (genvar g = 0; g < SERIAL_LENGTH; g++)
    begin : g_cfg
        if (g < NUM_SERIAL_REGS)
        begin : g_reg
            assign cfg_ext[g] = serial_cfg[g];
        end
        else
        begin : g_zero
            assign cfg_ext[g] = '0;
        end
    end

    assign field_off = pos_reg - POS_W'(FIELD_FIRST);

    always_comb
    begin
        field_zero = (data_byte == 8'h00);
        for (int i = 0; i < SERIAL_LENGTH - 1; i++)
        begin
            if (hold_reg[i] != 8'h00)
            begin
                field_zero = 1'b0;
            end
        end
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        pos_next        = pos_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        sum_next        = sum_reg;
        subst_next      = subst_reg;
        hold_wr         = 1'b0;
        grp_cnt         = '0;
        grp_bytes       = '0;
        grp_ctrl        = '0;

        if (!in_frame_reg)
        begin
            if (data_byte == SYX_START)
            begin
                in_frame_next = 1'b1;
                pos_next      = POS_W'(1);
                grp_bytes[0]  = data_byte;
                grp_cnt       = CNT_W'(1);
            end
        end
        else if (data_byte == SYX_END)
        begin
            grp_ctrl.last = 1'b1;
            if (pos_reg >= POS_W'(FIELD_FIRST) && pos_reg <= POS_W'(FIELD_LAST))
            begin
                // short frame: flush the held field bytes, then the end byte
                for (int i = 0; i < MAX_RESULTS; i++)
                begin
                    if (POS_W'(i) < field_off && i < SERIAL_LENGTH)
                    begin
                        grp_bytes[i] = hold_reg[i];
                    end
                    else if (POS_W'(i) == field_off)
                    begin
                        grp_bytes[i] = SYX_END;
                    end
                end
                grp_cnt = CNT_W'(field_off) + CNT_W'(1);
            end
            else if (pos_reg > POS_W'(FIELD_LAST) && pend_valid_reg)
            begin
                grp_bytes[0] = {1'b0, (~sum_reg + 7'd1) & LOW7};
                grp_bytes[1] = SYX_END;
                grp_cnt      = CNT_W'(2);
            end
            else
            begin
                grp_bytes[0] = SYX_END;
                grp_cnt      = CNT_W'(1);
            end
            in_frame_next   = 1'b0;
            pos_next        = '0;
            pend_valid_next = 1'b0;
            sum_next        = '0;
            subst_next      = 1'b0;
        end
        else
        begin
            if (pos_reg < POS_W'(FIELD_FIRST))
            begin
                grp_bytes[0] = data_byte;
                grp_cnt      = CNT_W'(1);
                if (pos_reg >= POS_W'(SUM_FIRST))
                begin
                    sum_next = sum_reg + data_byte[6:0];
                end
            end
            else if (pos_reg <= POS_W'(FIELD_LAST))
            begin
                hold_wr = 1'b1;
                if (pos_reg == POS_W'(FIELD_LAST))
                begin
                    if (field_zero)
                    begin
                        // all-zero field: send the configured serial, hold its last byte
                        subst_next = 1'b1;
                        for (int i = 0; i < SERIAL_LENGTH - 1; i++)
                        begin
                            grp_bytes[i] = cfg_ext[i];
                            sum_next     = sum_next + cfg_ext[i][6:0];
                        end
                        grp_cnt         = CNT_W'(SERIAL_LENGTH - 1);
                        pend_byte_next  = cfg_ext[SERIAL_LENGTH-1];
                        pend_valid_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < SERIAL_LENGTH - 1; i++)
                        begin
                            grp_bytes[i] = hold_reg[i];
                        end
                        grp_bytes[SERIAL_LENGTH-1] = data_byte;
                        grp_cnt = CNT_W'(SERIAL_LENGTH);
                    end
                end
            end
            else if (subst_reg)
            begin
                if (pend_valid_reg)
                begin
                    grp_bytes[0] = pend_byte_reg;
                    grp_cnt      = CNT_W'(1);
                    sum_next     = sum_reg + pend_byte_reg[6:0];
                end
                pend_byte_next  = data_byte;
                pend_valid_next = 1'b1;
            end
            else
            begin
                grp_bytes[0] = data_byte;
                grp_cnt      = CNT_W'(1);
            end
            pos_next = (pos_reg == POS_W'(POS_SAT)) ? pos_reg : pos_reg + POS_W'(1);
        end

        // frame still open at buffer end: one abort word replaces everything
        if (chunk_end && in_frame_next)
        begin
            grp_cnt         = CNT_W'(1);
            grp_bytes       = '0;
            grp_ctrl.last   = 1'b0;
            grp_ctrl.abort  = 1'b1;
            in_frame_next   = 1'b0;
            pos_next        = '0;
            pend_valid_next = 1'b0;
            sum_next        = '0;
            subst_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            sum_reg        <= '0;
            subst_reg      <= 1'b0;
        end
        else if (accept)
        begin
            in_frame_reg   <= in_frame_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            sum_reg        <= sum_next;
            subst_reg      <= subst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_byte_reg <= pend_byte_next;
            if (hold_wr)
            begin
                hold_reg[field_off[HOLD_W-1:0]] <= data_byte;
            end
        end
    end

endmodule

### sv/sspf_emit.sv
// result group register, drained one word per cycle onto the output channel while out_ready is high
module sspf_emit #(
    parameter int MAX_RESULTS = 5,
    parameter int CNT_W       = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [CNT_W-1:0]            grp_cnt,
    input  logic [MAX_RESULTS-1:0][7:0] grp_bytes,
    input  sspf_pkg::grp_ctrl_t         grp_ctrl,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        frame_last,
    output logic                        frame_abort
);
    import sspf_pkg::*;

    localparam int IDX_W = $clog2(MAX_RESULTS);

    logic                        valid_reg, valid_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    grp_ctrl_t                   ctrl_reg;
    logic                        at_end;
    logic                        pop;
    logic                        load;

    assign at_end   = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign pop      = valid_reg && out_ready;
    assign in_ready = !valid_reg || (pop && at_end);
    assign load     = accept && (grp_cnt != '0);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (pop)
        begin
            if (at_end)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = bytes_reg[idx_reg];
    assign frame_last  = valid_reg && ctrl_reg.last && at_end;
    assign frame_abort = valid_reg && ctrl_reg.abort;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cnt_reg   <= grp_cnt;
            bytes_reg <= grp_bytes;
            ctrl_reg  <= grp_ctrl;
        end
    end

endmodule

### sv/sysex_serial_patch_filter.sv
// top level of the sysex serial patch filter
//
//   channel   direction  handshake               payload
//   -------   ---------  ----------------------  ----------------------------------
//   input     in         in_valid / in_ready     data_byte, chunk_end
//   output    out        out_valid / out_ready   out_byte, frame_last, frame_abort
//   config    in         apb psel/penable/pready serial_byte_0..4 at 0x00..0x10
//
// one input word per cycle while out_ready is high and each word yields at most one output word
// a completed serial field or a frame close yields a burst of up to MAX_RESULTS
//   words; the result group register drains one word per cycle while out_ready is high,
//   and the input is held off until the last word of the burst is taken
// reset clears frame state and the serial registers; no clearing pass
// input ready follows out_ready combinationally through the group register
module sysex_serial_patch_filter #(
    parameter int SERIAL_LENGTH = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sspf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sspf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sspf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            chunk_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            frame_last,
    output logic                            frame_abort
);
    import sspf_pkg::*;

    // a closing byte of a patched frame needs the checksum plus end byte
    localparam int MAX_RESULTS = (SERIAL_LENGTH < 2) ? 2 : SERIAL_LENGTH;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    serial_cfg_t                 serial_cfg;
    logic                        accept;
    logic [CNT_W-1:0]            grp_cnt;
    logic [MAX_RESULTS-1:0][7:0] grp_bytes;
    grp_ctrl_t                   grp_ctrl;

    assign accept = in_valid && in_ready;

    sspf_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .serial_cfg (serial_cfg)
    );

    // frame state and patch decisions, one word per accept
    sspf_core #(
        .SERIAL_LENGTH (SERIAL_LENGTH),
        .MAX_RESULTS   (MAX_RESULTS),
        .CNT_W         (CNT_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .chunk_end  (chunk_end),
        .serial_cfg (serial_cfg),
        .grp_cnt    (grp_cnt),
        .grp_bytes  (grp_bytes),
        .grp_ctrl   (grp_ctrl)
    );

    // result group held here until every word is taken
    sspf_emit #(
        .MAX_RESULTS (MAX_RESULTS),
        .CNT_W       (CNT_W)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .grp_cnt     (grp_cnt),
        .grp_bytes   (grp_bytes),
        .grp_ctrl    (grp_ctrl),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .frame_last  (frame_last),
        .frame_abort (frame_abort)
    );

    // abort word carries no byte and never closes a frame
    a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
        frame_abort |-> (out_byte == 8'h00) && !frame_last)
        else $error("abort word carries data");

    // input is held off only while a group is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty group register");

    // frame close is always the end byte
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (out_byte == SYX_END))
        else $error("frame_last on a byte other than the end byte");

endmodule

### tb/testbench.sv
// self-checking testbench for the sysex serial patch filter
module testbench;
    import sspf_pkg::*;

    // serial field length the block is built with
    localparam int SER_LEN     = 5;
    localparam int FIELD_LAST  = FIELD_FIRST + SER_LEN - 1;
    localparam int POS_SAT     = FIELD_LAST + 2;
    // idle cycles granted after the last expected word before touching config
    localparam int TAIL_CYCLES = 12;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 80;
    // cycles with no handshake at all before the run is declared hung
    localparam int QUIET_LIMIT = 2000;

    // one input word and one output word as they travel over the channels
    typedef struct packed {
        byte_t b;
        logic  ce;
    } in_word_t;

    typedef struct packed {
        byte_t b;
        logic  last;
        logic  abort;
    } out_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte = 8'h00;
    logic                  chunk_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  frame_last;
    logic                  frame_abort;

    sysex_serial_patch_filter #(.SERIAL_LENGTH(SER_LEN)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .chunk_end   (chunk_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .frame_last  (frame_last),
        .frame_abort (frame_abort)
    );

    always #5 clk = ~clk;

    // words waiting to be sent, and words the filter must still produce
    in_word_t  send_queue [$];
    out_word_t patched_words [$];

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_received  = 0;
    int n_errors    = 0;
    int frame_items = 0;

    // hold-off request from the stimulus, answered by the receiver process
    int stall_req  = 0;
    int stall_ack  = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    // shadow of the serial registers
    serial_cfg_t serial_cfg = '0;

    // shadow of the filter's frame state
    bit         fr_open;
    int         fr_pos;
    byte_t      fld_hold [8];
    byte_t      held_byte;
    bit         held_ok;
    logic [6:0] csum;
    bit         patching;

    in_word_t  next_word;
    out_word_t want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch on %s: got %0h, expected %0h", what, got, exp_val);
        n_errors++;
    endtask

    task automatic drop_frame();
        fr_open  = 1'b0;
        fr_pos   = 0;
        held_ok  = 1'b0;
        csum     = '0;
        patching = 1'b0;
    endtask

    // work out the output words that one accepted input word causes
    task automatic filter_predict(input byte_t b, input logic ce);
        out_word_t  grp [$];
        int         p;
        bit         zero;
        logic [6:0] ck;
        if (!fr_open) begin
            // outside a frame only a start byte matters
            if (b == SYX_START) begin
                fr_open = 1'b1;
                fr_pos  = 1;
                grp.insert(grp.size(), {b, 1'b0, 1'b0});
            end
        end else begin
            p = fr_pos;
            if (b == SYX_END) begin
                if (p >= FIELD_FIRST && p <= FIELD_LAST) begin
                    // short frame ending inside the serial field: release held bytes as is
                    for (int i = 0; i + FIELD_FIRST < p; i++)
                        grp.insert(grp.size(), {fld_hold[i], 1'b0, 1'b0});
                end else if (p > FIELD_LAST && held_ok) begin
                    // byte before the end marker becomes the checksum
                    ck = 7'd0 - csum;
                    grp.insert(grp.size(), {1'b0, ck, 1'b0, 1'b0});
                end
                grp.insert(grp.size(), {b, 1'b1, 1'b0});
                drop_frame();
            end else begin
                if (p < FIELD_FIRST) begin
                    grp.insert(grp.size(), {b, 1'b0, 1'b0});
                    if (p >= SUM_FIRST)
                        csum = csum + b[6:0];
                end else if (p <= FIELD_LAST) begin
                    fld_hold[p - FIELD_FIRST] = b;
                    if (p == FIELD_LAST) begin
                        zero = 1'b1;
                        for (int i = 0; i < SER_LEN; i++)
                            if (fld_hold[i] != 8'h00)
                                zero = 1'b0;
                        if (zero) begin
                            // blank serial field: substitute, hold back the last byte
                            patching = 1'b1;
                            for (int i = 0; i < SER_LEN; i++)
                                fld_hold[i] = (i < NUM_SERIAL_REGS) ? serial_cfg[i] : 8'h00;
                            for (int i = 0; i + 1 < SER_LEN; i++) begin
                                grp.insert(grp.size(), {fld_hold[i], 1'b0, 1'b0});
                                csum = csum + fld_hold[i][6:0];
                            end
                            held_byte = fld_hold[SER_LEN - 1];
                            held_ok   = 1'b1;
                        end else begin
                            for (int i = 0; i < SER_LEN; i++)
                                grp.insert(grp.size(), {fld_hold[i], 1'b0, 1'b0});
                        end
                    end
                end else if (patching) begin
                    // patched frame: everything runs one byte late
                    if (held_ok) begin
                        grp.insert(grp.size(), {held_byte, 1'b0, 1'b0});
                        csum = csum + held_byte[6:0];
                    end
                    held_byte = b;
                    held_ok   = 1'b1;
                end else begin
                    grp.insert(grp.size(), {b, 1'b0, 1'b0});
                end
                fr_pos = (p + 1 < POS_SAT) ? p + 1 : POS_SAT;
            end
        end
        // buffer ends with a frame open: one abort word replaces everything
        if (ce && fr_open) begin
            grp.delete();
            grp.insert(grp.size(), {8'h00, 1'b0, 1'b1});
            drop_frame();
        end
        foreach (grp[i])
            patched_words.insert(patched_words.size(), grp[i]);
    endtask

    // sender: offers queued words, idles now and then, holds payload until taken
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            chunk_end <= 1'b0;
            drop_frame();
        end else begin
            if (in_valid && in_ready) begin
                filter_predict(data_byte, chunk_end);
                n_accepted++;
            end
            if (!in_valid || in_ready) begin
                // no idling while the accepted count sits in the calm window
                if (send_queue.size() > 0 &&
                    ((n_accepted >= 150 && n_accepted < 260) || $urandom_range(99) >= 7)) begin
                    next_word = send_queue.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= next_word.b;
                    chunk_end <= next_word.ce;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word against the oldest expectation, stalls at random
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_received++;
                if (patched_words.size() == 0) begin
                    report_mismatch("unexpected word", {out_byte, frame_last, frame_abort}, 0);
                end else begin
                    want = patched_words.pop_front();
                    if (out_byte !== want.b)
                        report_mismatch("out_byte", out_byte, want.b);
                    if (frame_last !== want.last)
                        report_mismatch("frame_last", frame_last, want.last);
                    if (frame_abort !== want.abort)
                        report_mismatch("frame_abort", frame_abort, want.abort);
                end
            end
            if (stall_ack != stall_req) begin
                // long hold-off so the block fills and backs up its input
                stall_ack <= stall_req;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (n_received >= 120 && n_received < 260) ||
                             $urandom_range(99) >= 7;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // apb write, entered right after a rising edge
    task automatic cfg_write(input reg_idx_t r, input byte_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        serial_cfg[r] = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_read_check(input reg_idx_t r, input byte_t exp_val);
        logic [CFG_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== {24'h0, exp_val})
            report_mismatch("serial register readback", got, exp_val);
    endtask

    task automatic program_serial(input serial_cfg_t s);
        for (int i = 0; i < NUM_SERIAL_REGS; i++)
            cfg_write(reg_idx_t'(i), s[i]);
        for (int i = 0; i < NUM_SERIAL_REGS; i++)
            cfg_read_check(reg_idx_t'(i), s[i]);
    endtask

    task automatic queue_word(input byte_t b, input logic ce);
        send_queue.insert(send_queue.size(), {b, ce});
        n_queued++;
    endtask

    // frame payload byte: anything but an end marker, now and then a start byte
    function automatic byte_t rand_payload();
        byte_t b;
        if ($urandom_range(15) == 0)
            return SYX_START;
        do b = byte_t'($urandom_range(255)); while (b == SYX_END);
        return b;
    endfunction

    // one frame with random content; mostly well formed, some short or cut off
    task automatic queue_frame();
        int    body;
        int    fld_mode;
        int    nz_pos;
        bit    cut;
        byte_t b;
        body     = ($urandom_range(9) == 0) ? $urandom_range(0, FIELD_LAST)
                                            : $urandom_range(FIELD_LAST + 1, 24);
        fld_mode = $urandom_range(9);
        nz_pos   = $urandom_range(FIELD_FIRST, FIELD_LAST);
        cut      = ($urandom_range(14) == 0);
        queue_word(SYX_START, cut && body == 0);
        for (int i = 1; i <= body; i++) begin
            b = rand_payload();
            if (i >= FIELD_FIRST && i <= FIELD_LAST) begin
                // blank field most of the time, else a single set byte or random bytes
                if (fld_mode < 6)
                    b = 8'h00;
                else if (fld_mode < 8)
                    b = (i == nz_pos) ? byte_t'($urandom_range(1, 255)) : 8'h00;
            end
            queue_word(b, cut && i == body);
        end
        if (!cut)
            queue_word(SYX_END, $urandom_range(9) == 0);
        frame_items += body + 1;
    endtask

    // bytes between frames, dropped by the filter
    task automatic queue_noise();
        byte_t b;
        repeat ($urandom_range(2)) begin
            do b = byte_t'($urandom_range(255)); while (b == SYX_START);
            queue_word(b, $urandom_range(7) == 0);
        end
    endtask

    task automatic queue_random(input int n_items);
        int stop_at;
        stop_at = frame_items + n_items;
        while (frame_items < stop_at) begin
            queue_noise();
            queue_frame();
        end
    endtask

    task automatic queue_directed();
        // blank serial field, start byte as data, checksum over 0x7f/0x80/serial
        byte_t patched [14] = '{SYX_START, 8'h01, 8'h02, SYX_START, 8'h04, 8'h7F, 8'h80,
                                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, SYX_END};
        // end marker two bytes into the serial field
        byte_t stubby [10] = '{SYX_START, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
                               8'h00, 8'h00, SYX_END};
        // stray bytes outside a frame, buffer end outside a frame
        queue_word(8'h00, 1'b0);
        queue_word(SYX_END, 1'b0);
        queue_word(8'hFF, 1'b1);
        // start byte as last byte of a buffer aborts at once
        queue_word(SYX_START, 1'b1);
        foreach (patched[i])
            queue_word(patched[i], 1'b0);
        foreach (stubby[i])
            queue_word(stubby[i], 1'b0);
    endtask

    // wait until every word has been taken and answered, then let the block go quiet
    task automatic settle();
        while (n_accepted != n_queued)
            @(posedge clk);
        while (patched_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial begin
        serial_cfg_t rnd_cfg;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // serial registers come out of reset cleared
        for (int i = 0; i < NUM_SERIAL_REGS; i++)
            cfg_read_check(reg_idx_t'(i), 8'h00);

        // mixed serial values, directed cases first
        program_serial({8'h55, 8'hFF, 8'h80, 8'h7F, 8'h00});
        queue_directed();
        queue_random(70);
        settle();

        // all ones, with a long receiver hold-off while the sender keeps going
        program_serial('1);
        stall_req++;
        queue_random(90);
        settle();

        // all zeros
        program_serial('0);
        queue_random(90);
        settle();

        // random serial number
        for (int i = 0; i < NUM_SERIAL_REGS; i++)
            rnd_cfg[i] = byte_t'($urandom_range(255));
        program_serial(rnd_cfg);
        queue_random(90);
        settle();

        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
